// File: hdl/sds_pkg.sv
// Shared constants for the stroke dab spacer: default sizes, configuration
// register indexes and event codes. No dependencies.
`default_nettype none

package sds_pkg;

    localparam int MAX_DABS_DEF   = 64;
    localparam int COORD_BITS_DEF = 13;
    localparam int FRAC_BITS_DEF  = 8;

    // Dab spacing register width in whole pixels.
    localparam int SPACING_W  = 10;
    localparam int CFG_ADDR_W = 1;
    localparam int TUSER_IN_W = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_DAB_SPACING   = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LAYER_VISIBLE = 1'd1;

    localparam logic [1:0] FUNC_PRESS   = 2'd0;
    localparam logic [1:0] FUNC_MOVE    = 2'd1;
    localparam logic [1:0] FUNC_RELEASE = 2'd2;

endpackage

`default_nettype wire

// File: hdl/sds_trialsub.sv
// Shared trial subtractor of the dab spacer: compares two unsigned words and
// gives their difference. Used by the square root and both dividers.
`default_nettype none

module sds_trialsub #(
    parameter int W = 25
) (
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output logic              ge,
    output logic [W-1:0]      diff
);

    logic borrow;

    assign {borrow, diff} = {1'b0, a} - {1'b0, b};
    assign ge = ~borrow;

endmodule

`default_nettype wire

// File: hdl/sds_mult.sv
// Shared signed multiplier of the dab spacer with a registered product.
// Squares the deltas and scales the unit vector by the step length.
`default_nettype none

module sds_mult #(
    parameter int AW = 14,
    parameter int BW = 19
) (
    input  wire logic                    aclk,
    input  wire logic signed [AW-1:0]    a,
    input  wire logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0]      p_reg
);

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

endmodule

`default_nettype wire

// File: hdl/stroke_dab_spacing.sv
// Stroke dab spacer top level: sequencer, state and output register.
// Depends on sds_pkg, sds_trialsub and sds_mult.
//
// Pointer events enter on the s_ channel (tdata: pointer_x, pointer_y from
// bit 0 up; tuser: func, left_button). Dab positions leave on the m_ channel
// with tlast on the final dab of an event. Registers are written through
// cfg_wr_en / cfg_addr / cfg_wdata; the user must do so only while the block is
// idle, which the block itself does not enforce. One event is worked at a time
// and s_tready is low until it is finished. A move runs the shared trial
// subtractor through a square root (COORD_BITS+FRAC_BITS+1 steps), the dab
// count division and two unit vector divisions (FRAC_BITS+1 steps each), then
// four products on the shared multiplier. Each dab is an accumulator add
// followed by an output transfer. When the receiver stalls, the sequencer
// waits with the next dab; nothing is dropped. Reset clears the drag flag,
// anchor and carried distance and sets the spacing to one pixel with the
// layer visible.
`default_nettype none

module stroke_dab_spacing #(
    parameter int MAX_DABS   = sds_pkg::MAX_DABS_DEF,
    parameter int COORD_BITS = sds_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sds_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // pointer_x, pointer_y, zero fill
    input  wire logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // func, left_button
    input  wire logic [sds_pkg::TUSER_IN_W-1:0]    s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // dab_x, dab_y, zero fill
    output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_tdata,
    output logic                                   m_tlast,
    input  wire logic                              cfg_wr_en,
    input  wire logic [sds_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [sds_pkg::SPACING_W-1:0]     cfg_wdata
);

    localparam int C       = COORD_BITS;
    localparam int F       = FRAC_BITS;
    localparam int SP_W    = sds_pkg::SPACING_W;
    localparam int TDATA_W = ((2*C+7)/8)*8;
    localparam int DX_W    = C + 1;
    localparam int SUM_W   = 2*C + 2;
    localparam int ROOT_W  = C + 1 + F;
    localparam int RAD_W   = 2*ROOT_W;
    localparam int SPQ_W   = SP_W + F;
    localparam int DIST_W  = ((C+1 > SP_W) ? C+1 : SP_W) + F + 1;
    localparam int ALU_W   = ((C+4 > SP_W+2) ? C+4 : SP_W+2) + F;
    localparam int QB      = $clog2(MAX_DABS+1);
    localparam int QW      = (QB > F+1) ? QB : F+1;
    localparam int U_W     = F + 2;
    localparam int STP_W   = SPQ_W + 1;
    localparam int MA      = (DX_W > U_W) ? DX_W : U_W;
    localparam int MB      = (DX_W > STP_W) ? DX_W : STP_W;
    localparam int MP      = MA + MB;
    localparam int ACC_W   = C + SP_W + 2*F + 8;
    localparam int ITER_W  = $clog2(ROOT_W+1);

    typedef enum logic [4:0] {
        S_IDLE, S_PRESS, S_SQX, S_SQY, S_SUM, S_SQRT, S_DIST, S_NCHK, S_NDIV,
        S_NEND, S_UXI, S_UXD, S_UYD, S_MUL1, S_MUL2, S_MUL3, S_MUL4, S_MUL5,
        S_STEP, S_OUT
    } state_t;

    state_t                   state_reg;
    logic                     drag_reg;
    logic                     visible_reg;
    logic [SP_W-1:0]          spacing_reg;
    logic signed [C-1:0]      anchor_x_reg, anchor_y_reg;
    logic signed [C-1:0]      px_reg, py_reg;
    logic [SPQ_W-1:0]         carried_reg, carry_next_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [RAD_W-1:0]         rad_reg;
    logic [ALU_W-1:0]         rem_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic [DIST_W-1:0]        dist_reg;
    logic [QW-1:0]            quot_reg;
    logic [ITER_W-1:0]        iter_reg;
    logic [QB-1:0]            left_cnt_reg;
    logic signed [U_W-1:0]    ux_reg, uy_reg;
    logic signed [MP-1:0]     incx0_reg, incy0_reg, incx_reg, incy_reg;
    logic signed [ACC_W-1:0]  accx_reg, accy_reg;
    logic                     first_reg;
    logic                     m_tvalid_reg;
    logic                     m_tlast_reg;
    logic [C-1:0]             dab_x_reg, dab_y_reg;

    logic [1:0]               in_func;
    logic                     in_left;
    logic signed [C-1:0]      in_x, in_y;
    logic                     accept;
    logic                     slot_free;
    logic                     dab_load;
    logic [SP_W-1:0]          sp;
    logic [SPQ_W-1:0]         spq;
    logic signed [DX_W-1:0]   dx, dy;
    logic [DX_W-1:0]          adx, ady;
    logic signed [STP_W-1:0]  stepq0;
    logic [ALU_W-1:0]         alu_a, alu_b, alu_diff, alu_r;
    logic                     alu_ge;
    logic signed [MA-1:0]     mul_a;
    logic signed [MB-1:0]     mul_b;
    logic signed [MP-1:0]     mul_p;
    logic [QW-1:0]            quot_nx;
    logic signed [U_W-1:0]    uq;
    logic [C-1:0]             out_x, out_y;
    logic                     negfrac_x, negfrac_y;

    assign in_func = s_tuser[1:0];
    assign in_left = s_tuser[2];
    assign in_x    = $signed(s_tdata[C-1:0]);
    assign in_y    = $signed(s_tdata[2*C-1:C]);

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !m_tvalid_reg || m_tready;
    // The output register takes a new dab in these two states only.
    assign dab_load  = slot_free && (state_reg == S_PRESS || state_reg == S_OUT);

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = TDATA_W'({dab_y_reg, dab_x_reg});

    // A spacing of zero behaves as one pixel.
    assign sp  = (spacing_reg == '0) ? SP_W'(1) : spacing_reg;
    assign spq = {sp, {F{1'b0}}};

    assign dx  = $signed({px_reg[C-1], px_reg}) - $signed({anchor_x_reg[C-1], anchor_x_reg});
    assign dy  = $signed({py_reg[C-1], py_reg}) - $signed({anchor_y_reg[C-1], anchor_y_reg});
    assign adx = dx[DX_W-1] ? (~dx + 1'b1) : dx;
    assign ady = dy[DX_W-1] ? (~dy + 1'b1) : dy;

    // The first step is shortened by the carried distance and may be negative.
    assign stepq0 = $signed({1'b0, spq}) - $signed({1'b0, carried_reg});

    always_comb begin
        alu_a = '0;
        alu_b = '0;
        case (state_reg)
            S_SQRT: begin
                alu_a = {rem_reg[ALU_W-3:0], rad_reg[RAD_W-1 -: 2]};
                alu_b = ALU_W'({root_reg, 2'b01});
            end
            S_NCHK: begin
                alu_a = ALU_W'(dist_reg[DIST_W-1:QB]);
                alu_b = ALU_W'(spq);
            end
            S_NDIV: begin
                alu_a = {rem_reg[ALU_W-2:0], rad_reg[RAD_W-1]};
                alu_b = ALU_W'(spq);
            end
            S_UXD, S_UYD: begin
                alu_a = {rem_reg[ALU_W-2:0], 1'b0};
                alu_b = ALU_W'(root_reg);
            end
            default: begin
            end
        endcase
    end

    sds_trialsub #(
        .W (ALU_W)
    ) u_trialsub (
        .a    (alu_a),
        .b    (alu_b),
        .ge   (alu_ge),
        .diff (alu_diff)
    );

    assign alu_r   = alu_ge ? alu_diff : alu_a;
    assign quot_nx = {quot_reg[QW-2:0], alu_ge};
    assign uq      = $signed({1'b0, quot_nx[F:0]});

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQX: begin
                mul_a = MA'(dx);
                mul_b = MB'(dx);
            end
            S_SQY: begin
                mul_a = MA'(dy);
                mul_b = MB'(dy);
            end
            S_MUL1: begin
                mul_a = MA'(ux_reg);
                mul_b = MB'(stepq0);
            end
            S_MUL2: begin
                mul_a = MA'(uy_reg);
                mul_b = MB'(stepq0);
            end
            S_MUL3: begin
                mul_a = MA'(ux_reg);
                mul_b = MB'($signed({1'b0, spq}));
            end
            S_MUL4: begin
                mul_a = MA'(uy_reg);
                mul_b = MB'($signed({1'b0, spq}));
            end
            default: begin
            end
        endcase
    end

    sds_mult #(
        .AW (MA),
        .BW (MB)
    ) u_mult (
        .aclk  (aclk),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (mul_p)
    );

    // Dab position is the accumulator truncated toward zero.
    assign negfrac_x = accx_reg[ACC_W-1] && (accx_reg[2*F-1:0] != '0);
    assign negfrac_y = accy_reg[ACC_W-1] && (accy_reg[2*F-1:0] != '0);
    assign out_x     = accx_reg[2*F+C-1:2*F] + C'(negfrac_x);
    assign out_y     = accy_reg[2*F+C-1:2*F] + C'(negfrac_y);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            drag_reg     <= 1'b0;
            visible_reg  <= 1'b1;
            spacing_reg  <= SP_W'(1);
            anchor_x_reg <= '0;
            anchor_y_reg <= '0;
            carried_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    sds_pkg::CFG_DAB_SPACING:   spacing_reg <= cfg_wdata;
                    sds_pkg::CFG_LAYER_VISIBLE: visible_reg <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end

            if (dab_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        px_reg <= in_x;
                        py_reg <= in_y;
                        case (in_func)
                            sds_pkg::FUNC_PRESS: begin
                                if (in_left && visible_reg) begin
                                    drag_reg     <= 1'b1;
                                    anchor_x_reg <= in_x;
                                    anchor_y_reg <= in_y;
                                    state_reg    <= S_PRESS;
                                end
                            end
                            sds_pkg::FUNC_MOVE: begin
                                if (drag_reg && visible_reg) begin
                                    state_reg <= S_SQX;
                                end
                            end
                            sds_pkg::FUNC_RELEASE: begin
                                if (in_left) begin
                                    drag_reg <= 1'b0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_PRESS: begin
                    if (slot_free) begin
                        m_tlast_reg  <= 1'b1;
                        dab_x_reg    <= px_reg;
                        dab_y_reg    <= py_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                S_SQX: begin
                    state_reg <= S_SQY;
                end
                S_SQY: begin
                    sum_reg   <= mul_p[SUM_W-1:0];
                    state_reg <= S_SUM;
                end
                S_SUM: begin
                    rad_reg   <= {SUM_W'(sum_reg + mul_p[SUM_W-1:0]), {(2*F){1'b0}}};
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    iter_reg  <= ITER_W'(ROOT_W);
                    state_reg <= S_SQRT;
                end
                S_SQRT: begin
                    rem_reg  <= alu_r;
                    root_reg <= {root_reg[ROOT_W-2:0], alu_ge};
                    rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                    iter_reg <= iter_reg - 1'b1;
                    if (iter_reg == ITER_W'(1)) begin
                        state_reg <= S_DIST;
                    end
                end
                S_DIST: begin
                    dist_reg  <= DIST_W'(carried_reg) + DIST_W'(root_reg);
                    state_reg <= S_NCHK;
                end
                S_NCHK: begin
                    // A quotient too wide for the dab count means the cap applies.
                    if (alu_ge) begin
                        left_cnt_reg   <= QB'(MAX_DABS);
                        carry_next_reg <= '0;
                        state_reg      <= S_UXI;
                    end else begin
                        rem_reg   <= alu_a;
                        rad_reg   <= {dist_reg[QB-1:0], {(RAD_W-QB){1'b0}}};
                        quot_reg  <= '0;
                        iter_reg  <= ITER_W'(QB);
                        state_reg <= S_NDIV;
                    end
                end
                S_NDIV: begin
                    rem_reg  <= alu_r;
                    quot_reg <= quot_nx;
                    rad_reg  <= {rad_reg[RAD_W-2:0], 1'b0};
                    iter_reg <= iter_reg - 1'b1;
                    if (iter_reg == ITER_W'(1)) begin
                        state_reg <= S_NEND;
                    end
                end
                S_NEND: begin
                    if (quot_reg[QB-1:0] == '0) begin
                        carried_reg  <= dist_reg[SPQ_W-1:0];
                        anchor_x_reg <= px_reg;
                        anchor_y_reg <= py_reg;
                        state_reg    <= S_IDLE;
                    end else if (quot_reg[QB-1:0] > QB'(MAX_DABS)) begin
                        left_cnt_reg   <= QB'(MAX_DABS);
                        carry_next_reg <= '0;
                        state_reg      <= S_UXI;
                    end else begin
                        left_cnt_reg   <= quot_reg[QB-1:0];
                        carry_next_reg <= rem_reg[SPQ_W-1:0];
                        state_reg      <= S_UXI;
                    end
                end
                S_UXI: begin
                    if (root_reg == '0) begin
                        ux_reg    <= '0;
                        uy_reg    <= '0;
                        state_reg <= S_MUL1;
                    end else begin
                        rem_reg   <= ALU_W'({adx, {(F-1){1'b0}}});
                        quot_reg  <= '0;
                        iter_reg  <= ITER_W'(F+1);
                        state_reg <= S_UXD;
                    end
                end
                S_UXD: begin
                    if (iter_reg == ITER_W'(1)) begin
                        ux_reg    <= dx[DX_W-1] ? -uq : uq;
                        rem_reg   <= ALU_W'({ady, {(F-1){1'b0}}});
                        quot_reg  <= '0;
                        iter_reg  <= ITER_W'(F+1);
                        state_reg <= S_UYD;
                    end else begin
                        rem_reg  <= alu_r;
                        quot_reg <= quot_nx;
                        iter_reg <= iter_reg - 1'b1;
                    end
                end
                S_UYD: begin
                    rem_reg  <= alu_r;
                    quot_reg <= quot_nx;
                    iter_reg <= iter_reg - 1'b1;
                    if (iter_reg == ITER_W'(1)) begin
                        uy_reg    <= dy[DX_W-1] ? -uq : uq;
                        state_reg <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    state_reg <= S_MUL2;
                end
                S_MUL2: begin
                    incx0_reg <= mul_p;
                    state_reg <= S_MUL3;
                end
                S_MUL3: begin
                    incy0_reg <= mul_p;
                    state_reg <= S_MUL4;
                end
                S_MUL4: begin
                    incx_reg  <= mul_p;
                    state_reg <= S_MUL5;
                end
                S_MUL5: begin
                    incy_reg  <= mul_p;
                    accx_reg  <= ACC_W'($signed({anchor_x_reg, {(2*F){1'b0}}}));
                    accy_reg  <= ACC_W'($signed({anchor_y_reg, {(2*F){1'b0}}}));
                    first_reg <= 1'b1;
                    state_reg <= S_STEP;
                end
                S_STEP: begin
                    accx_reg  <= accx_reg + ACC_W'(first_reg ? incx0_reg : incx_reg);
                    accy_reg  <= accy_reg + ACC_W'(first_reg ? incy0_reg : incy_reg);
                    first_reg <= 1'b0;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (slot_free) begin
                        m_tlast_reg  <= (left_cnt_reg == QB'(1));
                        dab_x_reg    <= out_x;
                        dab_y_reg    <= out_y;
                        left_cnt_reg <= left_cnt_reg - 1'b1;
                        if (left_cnt_reg == QB'(1)) begin
                            anchor_x_reg <= px_reg;
                            anchor_y_reg <= py_reg;
                            carried_reg  <= carry_next_reg;
                            state_reg    <= S_IDLE;
                        end else begin
                            state_reg <= S_STEP;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The square root remainder never exceeds twice the partial root.
    a_sqrt_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SQRT) |-> (rem_reg <= ALU_W'({root_reg, 1'b0})))
        else $error("square root remainder out of range");

    // The dab count division keeps its partial remainder below the spacing.
    a_ndiv_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_NDIV) |-> (rem_reg < ALU_W'(spq)))
        else $error("dab count remainder not below spacing");

    // Unit vector divisions keep their partial remainder below the length.
    a_udiv_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UXD || state_reg == S_UYD) |-> (rem_reg < ALU_W'(root_reg)))
        else $error("unit vector remainder not below segment length");

    // A dab is only ever issued while dabs remain for this move.
    a_left_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT || state_reg == S_STEP) |-> (left_cnt_reg != '0))
        else $error("dab issued with no dabs left");

endmodule

`default_nettype wire
